// ===== sv/pdda_pkg.sv =====
package pdda_pkg;

	// default configuration
	localparam int CHANNELS_DEF = 2;
	localparam int SAMPLES_DEF  = 10;

	// opcode values on the input port
	localparam logic [1:0] OPC_APPLY      = 2'd0;
	localparam logic [1:0] OPC_INVALIDATE = 2'd1;
	localparam logic [1:0] OPC_RESET      = 2'd2;
	localparam logic [1:0] OPC_CONSUME    = 2'd3;

	// accumulator limits
	localparam logic signed [15:0] SUM_MAX     = 16'sh7FFF;
	localparam logic signed [15:0] SUM_MIN     = 16'sh8000;
	localparam logic signed [15:0] CNT_MAX     = 16'sh7FFF;
	localparam logic signed [15:0] CNT_INVALID = 16'shFFFF;

	// operation as classified by the front end
	typedef enum logic [2:0] {
		K_NOP,
		K_APPLY,
		K_INVAL,
		K_CLEAR,
		K_CONSUME
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic               ch;
		logic signed [15:0] dx;
		logic signed [15:0] dy;
		logic [11:0]        div;
	} cmd_t;

	// back end sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MULT,
		ST_DIV
	} state_t;

	// divider request and response
	typedef struct packed {
		logic               start;
		logic signed [15:0] a_x;
		logic signed [15:0] a_y;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic signed [15:0] q_x;
		logic signed [15:0] q_y;
		logic signed [15:0] r_x;
		logic signed [15:0] r_y;
	} div_rsp_t;

	// signed 16-bit add with saturation
	function automatic logic signed [15:0] sat_add16(input logic signed [15:0] a,
		input logic signed [15:0] b);
		logic [16:0] s;
		s = {a[15], a} + {b[15], b};
		case (s[16:15])
			2'b01:   sat_add16 = SUM_MAX;
			2'b10:   sat_add16 = SUM_MIN;
			default: sat_add16 = s[15:0];
		endcase
	endfunction

endpackage

// ===== sv/pdda_front.sv =====
module pdda_front #(
	parameter int CHANNELS = pdda_pkg::CHANNELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic               channel,
	input  logic signed [15:0] dx,
	input  logic signed [15:0] dy,
	input  logic [11:0]        divisor,
	output logic               q_valid,
	output pdda_pkg::cmd_t     q_cmd,
	input  logic               q_pop
);

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	pdda_pkg::cmd_t    cmd_in;
	pdda_pkg::cmd_t    fifo_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              wr;
	logic              rd;

	// classify: range check, opcode decode, zero divisor acts as one
	always_comb begin
		cmd_in.ch  = channel;
		cmd_in.dx  = dx;
		cmd_in.dy  = dy;
		cmd_in.div = (divisor == 12'd0) ? 12'd1 : divisor;
		if (int'(channel) >= CHANNELS) begin
			cmd_in.kind = pdda_pkg::K_NOP;
		end else begin
			case (opcode)
				pdda_pkg::OPC_APPLY:      cmd_in.kind = pdda_pkg::K_APPLY;
				pdda_pkg::OPC_INVALIDATE: cmd_in.kind = pdda_pkg::K_INVAL;
				pdda_pkg::OPC_RESET:      cmd_in.kind = pdda_pkg::K_CLEAR;
				pdda_pkg::OPC_CONSUME:    cmd_in.kind = pdda_pkg::K_CONSUME;
				default:                  cmd_in.kind = pdda_pkg::K_NOP;
			endcase
		end
	end

	// command queue toward the back end
	assign in_ready = (count_q != QCNT_W'(QDEPTH));
	assign q_valid  = (count_q != '0);
	assign q_cmd    = fifo_q[rd_ptr_q];
	assign wr       = in_valid && in_ready;
	assign rd       = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (wr) begin
			fifo_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr, rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/pdda_divider.sv =====
module pdda_divider #(
	parameter int D_W = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pdda_pkg::div_req_t req,
	input  logic [D_W-1:0]     dvsr,
	output pdda_pkg::div_rsp_t rsp
);

	localparam int N     = 16;
	localparam int CNT_W = $clog2(N + 1);

	logic [D_W-1:0]    dvsr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [15:0]       mag_q [2];
	logic [D_W-1:0]    rem_q [2];
	logic              neg_q [2];
	logic signed [15:0] a_in  [2];
	logic [15:0]       q_out [2];
	logic [15:0]       r_out [2];

	assign a_in[0] = req.a_x;
	assign a_in[1] = req.a_y;

	// sequencing: one quotient bit per cycle on both axes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(N - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvsr_q <= dvsr;
		end
	end

	// restoring division lanes on magnitudes
	for (genvar g = 0; g < 2; g++) begin : g_lane
		logic [D_W:0]   trial;
		logic           ge;
		logic [D_W-1:0] rem_n;

		assign trial = {rem_q[g], mag_q[g][15]};
		assign ge    = (trial >= {1'b0, dvsr_q});
		assign rem_n = ge ? D_W'(trial - {1'b0, dvsr_q}) : D_W'(trial);

		always_ff @(posedge clk) begin
			if (req.start) begin
				mag_q[g] <= a_in[g][15] ? 16'(-a_in[g]) : a_in[g];
				rem_q[g] <= '0;
				neg_q[g] <= a_in[g][15];
			end else if (busy_q) begin
				mag_q[g] <= {mag_q[g][14:0], ge};
				rem_q[g] <= rem_n;
			end
		end

		// quotient and remainder take the sign of the dividend
		assign q_out[g] = neg_q[g] ? 16'(-mag_q[g]) : mag_q[g];
		assign r_out[g] = neg_q[g] ? 16'(-16'(rem_q[g])) : 16'(rem_q[g]);
	end

	assign rsp.done = done_q;
	assign rsp.q_x  = q_out[0];
	assign rsp.q_y  = q_out[1];
	assign rsp.r_x  = r_out[0];
	assign rsp.r_y  = r_out[1];

endmodule

// ===== sv/pdda_back.sv =====
module pdda_back #(
	parameter int CHANNELS = pdda_pkg::CHANNELS_DEF,
	parameter int SAMPLES  = pdda_pkg::SAMPLES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  pdda_pkg::cmd_t     q_cmd,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               accepted,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y
);

	localparam int CI_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int D_W  = 12 + $clog2(SAMPLES);
	localparam logic signed [15:0] SAMPLES_C = 16'(SAMPLES);

	logic signed [15:0] sum_x_q [CHANNELS];
	logic signed [15:0] sum_y_q [CHANNELS];
	logic signed [15:0] cnt_q   [CHANNELS];

	pdda_pkg::state_t   state_q;
	pdda_pkg::state_t   state_d;
	logic [CI_W-1:0]    idx;
	logic [CI_W-1:0]    ch_q;
	logic [D_W-1:0]     d_q;
	logic               out_valid_q;
	logic               accepted_q;
	logic signed [15:0] out_x_q;
	logic signed [15:0] out_y_q;
	logic               out_free;
	logic               consume_ok;
	logic               start_div;
	logic               wb;
	pdda_pkg::div_req_t div_req;
	pdda_pkg::div_rsp_t div_rsp;

	assign idx        = CI_W'(q_cmd.ch);
	assign out_free   = !out_valid_q || out_ready;
	assign consume_ok = (q_cmd.kind == pdda_pkg::K_CONSUME) && (cnt_q[idx] >= SAMPLES_C);

	// sequencer: short ops finish on pop, a ready consume runs the divider
	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		start_div = 1'b0;
		wb        = 1'b0;
		case (state_q)
			pdda_pkg::ST_IDLE: begin
				if (q_valid && out_free) begin
					q_pop = 1'b1;
					if (consume_ok) begin
						state_d = pdda_pkg::ST_MULT;
					end
				end
			end
			pdda_pkg::ST_MULT: begin
				start_div = 1'b1;
				state_d   = pdda_pkg::ST_DIV;
			end
			pdda_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					wb      = 1'b1;
					state_d = pdda_pkg::ST_IDLE;
				end
			end
			default: state_d = pdda_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pdda_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// consume operands: channel and divider product
	always_ff @(posedge clk) begin
		if (q_pop && consume_ok) begin
			ch_q <= idx;
			d_q  <= D_W'(32'(q_cmd.div) * 32'(SAMPLES));
		end
	end

	assign div_req.start = start_div;
	assign div_req.a_x   = sum_x_q[ch_q];
	assign div_req.a_y   = sum_y_q[ch_q];

	pdda_divider #(
		.D_W (D_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.dvsr   (d_q),
		.rsp    (div_rsp)
	);

	// per-channel accumulator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				sum_x_q[i] <= '0;
				sum_y_q[i] <= '0;
				cnt_q[i]   <= '0;
			end
		end else if (wb) begin
			sum_x_q[ch_q] <= div_rsp.r_x;
			sum_y_q[ch_q] <= div_rsp.r_y;
			cnt_q[ch_q]   <= '0;
		end else if (q_pop) begin
			case (q_cmd.kind)
				pdda_pkg::K_APPLY: begin
					sum_x_q[idx] <= pdda_pkg::sat_add16(sum_x_q[idx], q_cmd.dx);
					sum_y_q[idx] <= pdda_pkg::sat_add16(sum_y_q[idx], q_cmd.dy);
					if (cnt_q[idx] != pdda_pkg::CNT_MAX) begin
						cnt_q[idx] <= cnt_q[idx] + 16'sd1;
					end
				end
				pdda_pkg::K_INVAL: begin
					cnt_q[idx] <= pdda_pkg::CNT_INVALID;
				end
				pdda_pkg::K_CLEAR: begin
					sum_x_q[idx] <= '0;
					sum_y_q[idx] <= '0;
					cnt_q[idx]   <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wb || (q_pop && !consume_ok)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wb) begin
			accepted_q <= 1'b1;
			out_x_q    <= div_rsp.q_x;
			out_y_q    <= div_rsp.q_y;
		end else if (q_pop && !consume_ok) begin
			accepted_q <= 1'b0;
			out_x_q    <= '0;
			out_y_q    <= '0;
		end
	end

	assign out_valid = out_valid_q;
	assign accepted  = accepted_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;

endmodule

// ===== sv/pointer_delta_decimating_accumulator_unit.sv =====
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   opcode, channel, dx, dy, divisor
// out      output     out_valid / out_ready accepted, out_x, out_y
//
// apply, invalidate, reset and a refused consume finish in the back end on pop.
// a successful consume runs through pop (divider product formed there), load,
// 16 steps of the shared serial divider (one bit per cycle), then write-back.
// a two-entry command queue lets input transfers continue while the back end
// divides or the output register waits; reset clears all sums and counts.
module pointer_delta_decimating_accumulator_unit #(
	parameter int CHANNELS = pdda_pkg::CHANNELS_DEF,
	parameter int SAMPLES  = pdda_pkg::SAMPLES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic               channel,
	input  logic signed [15:0] dx,
	input  logic signed [15:0] dy,
	input  logic [11:0]        divisor,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               accepted,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y
);

	logic           q_valid;
	logic           q_pop;
	pdda_pkg::cmd_t q_cmd;

	// front end: classify and queue
	pdda_front #(
		.CHANNELS (CHANNELS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.opcode   (opcode),
		.channel  (channel),
		.dx       (dx),
		.dy       (dy),
		.divisor  (divisor),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop)
	);

	// back end: accumulate, divide, result register
	pdda_back #(
		.CHANNELS (CHANNELS),
		.SAMPLES  (SAMPLES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.accepted  (accepted),
		.out_x     (out_x),
		.out_y     (out_y)
	);

	// back end never pops an empty queue
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty command queue");

	// a command starts only when the output register can take its result
	a_pop_free: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (!out_valid || out_ready))
		else $error("command started with output register blocked");

	// results without a successful consume carry zero quotients
	a_zero_quot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !accepted) |-> (out_x == 16'sd0 && out_y == 16'sd0))
		else $error("nonzero quotient on a refused result");

endmodule
